/* sv/dda_pkg.sv */
`timescale 1ns / 1ps

package dda_pkg;

  localparam int COORD_BITS_DEF = 13;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COLOR_BITS     = 32;
  localparam int SCREEN_BITS    = 12;

  localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST  = 12'd800;
  localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = 12'd600;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_last;
    logic pixel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic line_active;
  } dp_sts_t;

endpackage

/* sv/dda_ctrl.sv */
`timescale 1ns / 1ps

module dda_ctrl #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  input  dda_pkg::dp_sts_t  sts,
  output dda_pkg::ctrl_cmd_t cmd
);
  import dda_pkg::*;

  localparam int DIV_STEPS = COORD_BITS + FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               in_fire;
  logic               cnt_end;

  assign cnt_end   = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.load     = in_fire && (in_cmd == CMD_LOAD);
    cmd.pixel    = in_fire && (in_cmd == CMD_STEP) && sts.line_active;
    cmd.div_step = (state_r == S_DIV);
    cmd.div_last = (state_r == S_DIV) && cnt_end;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_DIV;
          cnt_nxt   = '0;
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.pixel) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_DIV) && (cnt_r == '0))
    else $error("load did not start the divider");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_last |=> (state_r == S_IDLE))
    else $error("divider did not return to idle");

  a_pixel_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pixel |=> out_valid_r)
    else $error("pixel transfer lost");

  a_no_take_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> !in_fire && !cmd.pixel)
    else $error("input taken while dividing");

endmodule

/* sv/dda_datapath.sv */
`timescale 1ns / 1ps

module dda_datapath #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dda_pkg::ctrl_cmd_t                  cmd,
  output dda_pkg::dp_sts_t                    sts,
  input  logic                                cfg_valid,
  input  logic                                cfg_index,
  input  logic [dda_pkg::SCREEN_BITS-1:0]     cfg_data,
  input  logic signed [COORD_BITS-1:0]        in_start_x,
  input  logic signed [COORD_BITS-1:0]        in_start_y,
  input  logic signed [COORD_BITS-1:0]        in_end_x,
  input  logic signed [COORD_BITS-1:0]        in_end_y,
  input  logic [dda_pkg::COLOR_BITS-1:0]      in_line_color,
  output logic signed [COORD_BITS-1:0]        out_pixel_x,
  output logic signed [COORD_BITS-1:0]        out_pixel_y,
  output logic [dda_pkg::COLOR_BITS-1:0]      out_pixel_color,
  output logic                                out_inside_window,
  output logic                                out_last_pixel
);
  import dda_pkg::*;

  localparam int POS_W  = COORD_BITS + FRAC_BITS + 1;
  localparam int STEP_W = FRAC_BITS + 2;
  localparam int LEFT_W = COORD_BITS + 1;
  localparam int D_W    = COORD_BITS + 1;
  localparam int NUM_W  = COORD_BITS + FRAC_BITS + 1;
  localparam int CMP_W  = (COORD_BITS - 1 > SCREEN_BITS) ? COORD_BITS - 1 : SCREEN_BITS;
  localparam logic [POS_W-1:0] HALF =
    {{(POS_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  // one restoring-division bit: returns {new remainder, quotient bit}
  function automatic logic [COORD_BITS:0] div_iter(input logic [COORD_BITS-1:0] rem,
                                                   input logic msb,
                                                   input logic [COORD_BITS-1:0] dv);
    logic [D_W-1:0] trial;
    logic [D_W-1:0] diff;
    trial = {rem, msb};
    diff  = trial - {1'b0, dv};
    if (trial >= {1'b0, dv}) begin
      div_iter = {diff[COORD_BITS-1:0], 1'b1};
    end else begin
      div_iter = {trial[COORD_BITS-1:0], 1'b0};
    end
  endfunction

  // half away from zero: add half, or half minus one when negative, then floor
  function automatic logic [COORD_BITS-1:0] round_pix(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] s;
    s = p + (p[POS_W-1] ? (HALF - 1'b1) : HALF);
    round_pix = s[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
  endfunction

  function automatic logic in_range(input logic [COORD_BITS-1:0] v,
                                    input logic [SCREEN_BITS-1:0] lim);
    in_range = !v[COORD_BITS-1] && (CMP_W'(v[COORD_BITS-2:0]) < CMP_W'(lim));
  endfunction

  logic [SCREEN_BITS-1:0]   width_r, height_r;
  logic [POS_W-1:0]         pos_x_r, pos_y_r;
  logic [STEP_W-1:0]        step_x_r, step_y_r;
  logic [LEFT_W-1:0]        left_r;
  logic [COLOR_BITS-1:0]    color_r;
  logic                     active_r;
  logic [COORD_BITS-1:0]    span_r;
  logic                     neg_x_r, neg_y_r;
  logic [COORD_BITS-1:0]    rem_x_r, rem_y_r;
  logic [NUM_W-1:0]         quo_x_r, quo_y_r;

  logic [D_W-1:0]           dx, dy, mag_x_full, mag_y_full;
  logic [COORD_BITS-1:0]    mag_x, mag_y, span;
  logic [NUM_W-1:0]         num_x, num_y;
  logic [COORD_BITS:0]      it_x, it_y;
  logic [NUM_W-1:0]         quo_x_nxt, quo_y_nxt;
  logic [STEP_W-1:0]        q_x, q_y;
  logic [COORD_BITS-1:0]    pix_x, pix_y;

  assign sts.line_active = active_r;

  // load: deltas, magnitudes, span and rounded numerators
  assign dx = {in_end_x[COORD_BITS-1], in_end_x} - {in_start_x[COORD_BITS-1], in_start_x};
  assign dy = {in_end_y[COORD_BITS-1], in_end_y} - {in_start_y[COORD_BITS-1], in_start_y};
  assign mag_x_full = dx[COORD_BITS] ? (D_W'(0) - dx) : dx;
  assign mag_y_full = dy[COORD_BITS] ? (D_W'(0) - dy) : dy;
  assign mag_x = mag_x_full[COORD_BITS-1:0];
  assign mag_y = mag_y_full[COORD_BITS-1:0];
  assign span  = (mag_x > mag_y) ? mag_x : mag_y;
  assign num_x = NUM_W'({mag_x, {FRAC_BITS{1'b0}}}) + NUM_W'(span[COORD_BITS-1:1]);
  assign num_y = NUM_W'({mag_y, {FRAC_BITS{1'b0}}}) + NUM_W'(span[COORD_BITS-1:1]);

  assign it_x = div_iter(rem_x_r, quo_x_r[NUM_W-1], span_r);
  assign it_y = div_iter(rem_y_r, quo_y_r[NUM_W-1], span_r);
  assign quo_x_nxt = {quo_x_r[NUM_W-2:0], it_x[0]};
  assign quo_y_nxt = {quo_y_r[NUM_W-2:0], it_y[0]};
  assign q_x = STEP_W'({1'b0, quo_x_nxt[FRAC_BITS:0]});
  assign q_y = STEP_W'({1'b0, quo_y_nxt[FRAC_BITS:0]});

  assign pix_x = round_pix(pos_x_r);
  assign pix_y = round_pix(pos_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SCREEN_WIDTH_RST;
      height_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  width_r  <= cfg_data;
        REG_SCREEN_HEIGHT: height_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (cmd.load) begin
      active_r <= 1'b1;
    end else if (cmd.pixel && (left_r == LEFT_W'(1))) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_x_r <= {in_start_x[COORD_BITS-1], in_start_x, {FRAC_BITS{1'b0}}};
      pos_y_r <= {in_start_y[COORD_BITS-1], in_start_y, {FRAC_BITS{1'b0}}};
      left_r  <= LEFT_W'(span) + 1'b1;
      color_r <= in_line_color;
      span_r  <= span;
      neg_x_r <= dx[COORD_BITS];
      neg_y_r <= dy[COORD_BITS];
      rem_x_r <= '0;
      rem_y_r <= '0;
      quo_x_r <= num_x;
      quo_y_r <= num_y;
    end else if (cmd.div_step) begin
      rem_x_r <= it_x[COORD_BITS:1];
      rem_y_r <= it_y[COORD_BITS:1];
      quo_x_r <= quo_x_nxt;
      quo_y_r <= quo_y_nxt;
    end else if (cmd.pixel) begin
      pos_x_r <= pos_x_r + {{(POS_W-STEP_W){step_x_r[STEP_W-1]}}, step_x_r};
      pos_y_r <= pos_y_r + {{(POS_W-STEP_W){step_y_r[STEP_W-1]}}, step_y_r};
      left_r  <= left_r - 1'b1;
    end
  end

  // zero-length line: the divider ran on a zero divisor, force still steps
  always_ff @(posedge clk) begin
    if (cmd.div_last) begin
      if (span_r == '0) begin
        step_x_r <= '0;
        step_y_r <= '0;
      end else begin
        step_x_r <= neg_x_r ? (STEP_W'(0) - q_x) : q_x;
        step_y_r <= neg_y_r ? (STEP_W'(0) - q_y) : q_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pixel) begin
      out_pixel_x       <= pix_x;
      out_pixel_y       <= pix_y;
      out_pixel_color   <= color_r;
      out_inside_window <= in_range(pix_x, width_r) && in_range(pix_y, height_r);
      out_last_pixel    <= (left_r == LEFT_W'(1));
    end
  end

  a_active_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (left_r != '0))
    else $error("active line with no pixels left");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pixel && (left_r == LEFT_W'(1)) && !cmd.load) |=> !active_r)
    else $error("line stayed active after its last pixel");

  a_load_activates: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> active_r)
    else $error("load did not start a line");

endmodule

/* sv/dda_line_rasterizer.sv */
`timescale 1ns / 1ps

// DDA line rasterizer. A load transfer (in_cmd = 0) takes two end points and a
// color and then runs a one-bit-per-cycle restoring divider, which forms the
// Q-format x and y steps; in_ready is low while the divider runs. Each step
// transfer (in_cmd = 1) then gives one pixel through a registered output
// stage, one per cycle while the consumer keeps out_ready high, span + 1
// pixels per line with out_last_pixel on the final one. A step sent with no
// line loaded is taken and dropped. Configuration writes are always taken.
module dda_line_rasterizer #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [dda_pkg::SCREEN_BITS-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic signed [COORD_BITS-1:0]    in_start_x,
  input  logic signed [COORD_BITS-1:0]    in_start_y,
  input  logic signed [COORD_BITS-1:0]    in_end_x,
  input  logic signed [COORD_BITS-1:0]    in_end_y,
  input  logic [dda_pkg::COLOR_BITS-1:0]  in_line_color,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [COORD_BITS-1:0]    out_pixel_x,
  output logic signed [COORD_BITS-1:0]    out_pixel_y,
  output logic [dda_pkg::COLOR_BITS-1:0]  out_pixel_color,
  output logic                            out_inside_window,
  output logic                            out_last_pixel
);
  import dda_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  dda_ctrl #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dda_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_end_x          (in_end_x),
    .in_end_y          (in_end_y),
    .in_line_color     (in_line_color),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_color   (out_pixel_color),
    .out_inside_window (out_inside_window),
    .out_last_pixel    (out_last_pixel)
  );

endmodule
